FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion macros shared by the rtl, compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/core/sme_pkg.sv
// ----------------------------------------------------------------------------
// sme_pkg
// shared types and constants of the stack machine executor
// ----------------------------------------------------------------------------
package sme_pkg;

	localparam int WORD_W = 32;
	localparam int CMD_W = 4;
	localparam int STATUS_W = 3;
	localparam int STACK_DEPTH_DEF = 64;

	typedef enum logic [CMD_W-1:0] {
		OP_PUSH  = 4'd0,
		OP_POP   = 4'd1,
		OP_SWAP  = 4'd2,
		OP_ADD   = 4'd3,
		OP_SUB   = 4'd4,
		OP_MUL   = 4'd5,
		OP_DIV   = 4'd6,
		OP_MOD   = 4'd7,
		OP_PEEK  = 4'd8,
		OP_PRINT = 4'd9,
		OP_NOP   = 4'd10
	} op_code_t;

	localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd1;
	localparam logic [STATUS_W-1:0] ST_SHORT = 3'd2;
	localparam logic [STATUS_W-1:0] ST_DIVZ  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FULL  = 3'd4;

	typedef enum logic [2:0] {
		DP_NONE,
		DP_PUSH,
		DP_POP,
		DP_SWAP,
		DP_ALU
	} dp_op_t;

	typedef struct packed {
		dp_op_t              op;
		logic [CMD_W-1:0]    alu_fn;
		logic                in_load;
		logic                rd_en;
		logic                rd_use_ptr;
		logic                ptr_load;
		logic                ptr_dec;
		logic                div_start;
		logic                out_load;
		logic                out_sel_rd;
		logic [STATUS_W-1:0] out_status;
		logic                out_last;
	} dp_cmd_t;

	typedef struct packed {
		logic cnt_zero;
		logic cnt_lt2;
		logic cnt_full;
		logic top_zero;
		logic ptr_zero;
		logic div_done;
		logic out_free;
	} dp_stat_t;

endpackage

FILE: rtl/core/sme_div.sv
// ----------------------------------------------------------------------------
// sme_div
// signed 32-bit divider, shift-subtract, one quotient bit per cycle
// ----------------------------------------------------------------------------
module sme_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [sme_pkg::WORD_W-1:0]  dividend,
	input  logic [sme_pkg::WORD_W-1:0]  divisor,
	output logic                        done,
	output logic [sme_pkg::WORD_W-1:0]  quotient,
	output logic [sme_pkg::WORD_W-1:0]  remainder
);
	import sme_pkg::*;

	localparam int SW = $clog2(WORD_W);

	logic [WORD_W-1:0] rem_q, quo_q, dvs_q;
	logic [SW-1:0]     cnt_q;
	logic              busy_q, done_q, negq_q, negr_q;
	logic [WORD_W:0]   trial;
	logic              ge;
	logic [WORD_W:0]   diff;

	assign trial = {rem_q, quo_q[WORD_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == SW'(WORD_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quo_q  <= dividend[WORD_W-1] ? (~dividend + 1'b1) : dividend;
			dvs_q  <= divisor[WORD_W-1] ? (~divisor + 1'b1) : divisor;
			negq_q <= dividend[WORD_W-1] ^ divisor[WORD_W-1];
			negr_q <= dividend[WORD_W-1];
			cnt_q  <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
			quo_q <= {quo_q[WORD_W-2:0], ge};
			cnt_q <= cnt_q + 1'b1;
		end
	end

	assign done      = done_q;
	assign quotient  = negq_q ? (~quo_q + 1'b1) : quo_q;
	assign remainder = negr_q ? (~rem_q + 1'b1) : rem_q;

endmodule

FILE: rtl/core/sme_dp.sv
// ----------------------------------------------------------------------------
// sme_dp
// stack datapath: stack memory, top register, alu, divider, output register
// ----------------------------------------------------------------------------
module sme_dp #(
	parameter int STACK_DEPTH = sme_pkg::STACK_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  sme_pkg::dp_cmd_t                   cmd,
	output sme_pkg::dp_stat_t                  stat,
	input  logic signed [sme_pkg::WORD_W-1:0]  push_value,
	input  logic                               out_ready,
	output logic                               out_valid,
	output logic signed [sme_pkg::WORD_W-1:0]  result_value,
	output logic [sme_pkg::STATUS_W-1:0]       status,
	output logic                               last
);
	import sme_pkg::*;

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);

	logic [WORD_W-1:0]   mem [STACK_DEPTH];
	logic [CW-1:0]       count_q;
	logic [AW-1:0]       ptr_q;
	logic [WORD_W-1:0]   top_q, rd_q, val_q;
	logic [CW-1:0]       cnt_m1, cnt_m2;
	logic [AW-1:0]       rd_addr, wr_addr;
	logic                wr_en;
	logic [WORD_W-1:0]   alu_r, mul_lo, div_q, div_r, topz;
	logic                div_done;
	logic                valid_q;
	logic [WORD_W-1:0]   res_q;
	logic [STATUS_W-1:0] status_q;
	logic                last_q;

	assign cnt_m1  = count_q - 1'b1;
	assign cnt_m2  = count_q - CW'(2);
	assign rd_addr = cmd.rd_use_ptr ? ptr_q : cnt_m2[AW-1:0];
	assign wr_en   = (cmd.op == DP_PUSH && count_q != '0) || cmd.op == DP_SWAP;
	assign wr_addr = (cmd.op == DP_SWAP) ? cnt_m2[AW-1:0] : cnt_m1[AW-1:0];

	// top of stack lives in top_q, entries below it in memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= top_q;
		end
		if (cmd.rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	sme_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (rd_q),
		.divisor   (top_q),
		.done      (div_done),
		.quotient  (div_q),
		.remainder (div_r)
	);

	assign mul_lo = rd_q * top_q;

	always_comb begin
		case (cmd.alu_fn)
			OP_ADD:  alu_r = rd_q + top_q;
			OP_SUB:  alu_r = rd_q - top_q;
			OP_MUL:  alu_r = mul_lo;
			OP_DIV:  alu_r = div_q;
			OP_MOD:  alu_r = div_r;
			default: alu_r = rd_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			case (cmd.op)
				DP_PUSH: count_q <= count_q + 1'b1;
				DP_POP:  count_q <= cnt_m1;
				DP_ALU:  count_q <= cnt_m1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.in_load) begin
			val_q <= push_value;
		end
		case (cmd.op)
			DP_PUSH: top_q <= val_q;
			DP_POP:  top_q <= rd_q;
			DP_SWAP: top_q <= rd_q;
			DP_ALU:  top_q <= alu_r;
			default: top_q <= top_q;
		endcase
		if (cmd.ptr_load) begin
			ptr_q <= cnt_m2[AW-1:0];
		end else if (cmd.ptr_dec) begin
			ptr_q <= ptr_q - 1'b1;
		end
	end

	assign topz = (count_q == '0) ? '0 : top_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res_q    <= cmd.out_sel_rd ? rd_q : topz;
			status_q <= cmd.out_status;
			last_q   <= cmd.out_last;
		end
	end

	assign stat.cnt_zero = count_q == '0;
	assign stat.cnt_lt2  = count_q < CW'(2);
	assign stat.cnt_full = count_q >= CW'(STACK_DEPTH);
	assign stat.top_zero = top_q == '0;
	assign stat.ptr_zero = ptr_q == '0;
	assign stat.div_done = div_done;
	assign stat.out_free = !valid_q || out_ready;

	assign out_valid    = valid_q;
	assign result_value = res_q;
	assign status       = status_q;
	assign last         = last_q;

endmodule

FILE: rtl/core/sme_ctrl.sv
// ----------------------------------------------------------------------------
// sme_ctrl
// command sequencer: decodes one command and steps the datapath through it
// ----------------------------------------------------------------------------
module sme_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [sme_pkg::CMD_W-1:0]   command,
	input  sme_pkg::dp_stat_t           stat,
	output sme_pkg::dp_cmd_t            cmd
);
	import sme_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_POP_FIN,
		S_SWAP_FIN,
		S_ALU_FIN,
		S_DIV_GO,
		S_DIV_WAIT,
		S_EMIT,
		S_PR_RD,
		S_PR_EMIT
	} state_t;

	state_t              state_q;
	logic [CMD_W-1:0]    cmd_q;
	logic [STATUS_W-1:0] emit_status_q;
	logic                emit_last_q;
	logic                print_q;
	logic                accept;

	assign in_ready = state_q == S_IDLE;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			cmd_q         <= OP_NOP;
			emit_status_q <= ST_OK;
			emit_last_q   <= 1'b1;
			print_q       <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q   <= command;
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					emit_status_q <= ST_OK;
					emit_last_q   <= 1'b1;
					print_q       <= 1'b0;
					state_q       <= S_EMIT;
					case (cmd_q)
						OP_PUSH: begin
							if (stat.cnt_full) begin
								emit_status_q <= ST_FULL;
							end
						end
						OP_POP: begin
							if (stat.cnt_zero) begin
								emit_status_q <= ST_EMPTY;
							end else begin
								state_q <= S_POP_FIN;
							end
						end
						OP_SWAP: begin
							if (stat.cnt_lt2) begin
								emit_status_q <= ST_SHORT;
							end else begin
								state_q <= S_SWAP_FIN;
							end
						end
						OP_ADD, OP_SUB, OP_MUL: begin
							if (stat.cnt_lt2) begin
								emit_status_q <= ST_SHORT;
							end else begin
								state_q <= S_ALU_FIN;
							end
						end
						OP_DIV, OP_MOD: begin
							if (stat.cnt_lt2) begin
								emit_status_q <= ST_SHORT;
							end else if (stat.top_zero) begin
								emit_status_q <= ST_DIVZ;
							end else begin
								state_q <= S_DIV_GO;
							end
						end
						OP_PEEK: begin
							if (stat.cnt_zero) begin
								emit_status_q <= ST_EMPTY;
							end
						end
						OP_PRINT: begin
							emit_last_q <= stat.cnt_lt2;
							print_q     <= 1'b1;
						end
						default: begin
							emit_status_q <= ST_OK;
						end
					endcase
				end
				S_POP_FIN:  state_q <= S_EMIT;
				S_SWAP_FIN: state_q <= S_EMIT;
				S_ALU_FIN:  state_q <= S_EMIT;
				S_DIV_GO:   state_q <= S_DIV_WAIT;
				S_DIV_WAIT: begin
					if (stat.div_done) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (stat.out_free) begin
						state_q <= (print_q && !emit_last_q) ? S_PR_RD : S_IDLE;
					end
				end
				S_PR_RD: state_q <= S_PR_EMIT;
				S_PR_EMIT: begin
					if (stat.out_free) begin
						state_q <= stat.ptr_zero ? S_IDLE : S_PR_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd            = '0;
		cmd.op         = DP_NONE;
		cmd.alu_fn     = cmd_q;
		cmd.in_load    = accept;
		cmd.out_status = emit_status_q;
		cmd.out_last   = emit_last_q;
		case (state_q)
			S_DECODE: begin
				case (cmd_q)
					OP_PUSH: begin
						if (!stat.cnt_full) begin
							cmd.op = DP_PUSH;
						end
					end
					OP_POP, OP_SWAP, OP_ADD, OP_SUB, OP_MUL: begin
						cmd.rd_en = !stat.cnt_lt2;
					end
					OP_DIV, OP_MOD: begin
						cmd.rd_en = !stat.cnt_lt2 && !stat.top_zero;
					end
					OP_PRINT: begin
						cmd.ptr_load = 1'b1;
					end
					default: begin
						cmd.op = DP_NONE;
					end
				endcase
			end
			S_POP_FIN:  cmd.op = DP_POP;
			S_SWAP_FIN: cmd.op = DP_SWAP;
			S_ALU_FIN:  cmd.op = DP_ALU;
			S_DIV_GO:   cmd.div_start = 1'b1;
			S_DIV_WAIT: begin
				if (stat.div_done) begin
					cmd.op = DP_ALU;
				end
			end
			S_EMIT: begin
				cmd.out_load = stat.out_free;
			end
			S_PR_RD: begin
				cmd.rd_en      = 1'b1;
				cmd.rd_use_ptr = 1'b1;
			end
			S_PR_EMIT: begin
				cmd.out_load   = stat.out_free;
				cmd.out_sel_rd = 1'b1;
				cmd.out_status = ST_OK;
				cmd.out_last   = stat.ptr_zero;
				cmd.ptr_dec    = stat.out_free && !stat.ptr_zero;
			end
			default: begin
				cmd.op = DP_NONE;
			end
		endcase
	end

endmodule

FILE: rtl/core/stack_machine_executor_unit.sv
// ----------------------------------------------------------------------------
// stack_machine_executor_unit
// stack machine on a bounded stack of signed 32-bit words
// ----------------------------------------------------------------------------
// input channel: in_valid/in_ready with command and push_value; one command
// per transaction. output channel: out_valid/out_ready with result_value,
// status and last; every command gives one transaction, print-all one per
// stack word (a zero when empty), top first, last set on the final one.
// a command is taken only while the sequencer is idle. after decode, push,
// peek, nop and all errors go straight to the output load; pop, swap, add,
// sub and mul pass a finishing state first; div and mod start the 32-step
// shift-subtract divider and wait for its done. print-all loads the top
// word, then one read of the stack memory and one load per further word.
// the next command can be taken in the cycle after the last output is loaded.
// results sit in an output register; while the receiver stalls a finished
// result is held there and the sequencer waits before loading the next one.
// reset empties the stack and the output register; stack memory is not
// cleared, only words that were pushed are ever read.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stack_machine_executor_unit #(
	parameter int STACK_DEPTH = sme_pkg::STACK_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [sme_pkg::CMD_W-1:0]          command,
	input  logic signed [sme_pkg::WORD_W-1:0]  push_value,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [sme_pkg::WORD_W-1:0]  result_value,
	output logic [sme_pkg::STATUS_W-1:0]       status,
	output logic                               last
);
	import sme_pkg::*;

	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;

	sme_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.command  (command),
		.stat     (dp_stat),
		.cmd      (dp_cmd)
	);

	sme_dp #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (dp_cmd),
		.stat         (dp_stat),
		.push_value   (push_value),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.result_value (result_value),
		.status       (status),
		.last         (last)
	);

	`ASSERT_IMPL(a_load_when_free, clk, arst_n, dp_cmd.out_load, dp_stat.out_free)
	`ASSERT_IMPL(a_no_push_full, clk, arst_n, dp_cmd.op == DP_PUSH, !dp_stat.cnt_full)
	`ASSERT_IMPL(a_read_in_range, clk, arst_n, dp_cmd.rd_en && !dp_cmd.rd_use_ptr, !dp_stat.cnt_lt2)
	`ASSERT_NEXT(a_one_at_a_time, clk, arst_n, in_valid && in_ready, !in_ready)

endmodule
